// File: rtl/core/resource_lease_lock_table_defines.svh
// ----------------------------------------------------------------------------
// Lease lock table assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_LEASE_LOCK_TABLE_DEFINES_SVH
`define RESOURCE_LEASE_LOCK_TABLE_DEFINES_SVH

// same-cycle implication, reset masked
`define RLT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlt check failed");

// next-cycle implication, reset masked
`define RLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlt check failed");

`endif

// File: rtl/core/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Lease lock table package
// Sizes, codes and word types shared by the lease table files.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int DEPTH     = 32;
    localparam int ROW_AW    = 5;
    localparam int CNT_W     = 6;
    localparam int MAX_GROUP = 8;
    localparam int STG_AW    = 3;
    localparam int STG_CW    = 4;
    localparam int KEY_W     = 16;
    localparam int OWN_W     = 8;
    localparam int LEASE_W   = 32;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [STG_CW-1:0]  t_scnt;
    typedef logic [CNT_W:0]     t_sum;
    typedef logic [LEASE_W-1:0] t_lease;

    typedef enum logic [1:0] {
        ACT_CLAIM = 2'd0,
        ACT_LEASE = 2'd1,
        ACT_OWNER = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   resource_key;
        logic [OWN_W-1:0]   owner_id;
        logic               mode;
        logic               notify_on_release;
        logic [LEASE_W-1:0] lease_in;
        logic               group_last;
    } t_in;

    typedef struct packed {
        logic               kind;
        t_status            status;
        logic [OWN_W-1:0]   owner_out;
        logic [KEY_W-1:0]   resource_out;
        logic [LEASE_W-1:0] lease_out;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]   resource;
        logic [OWN_W-1:0]   owner;
        logic [LEASE_W-1:0] lease;
        logic               mode;
        logic               primary;
        logic               notify;
    } t_row;

endpackage

// File: rtl/core/resource_lease_lock_table.sv
// ----------------------------------------------------------------------------
// Resource lease lock table
// Reader/writer lease table over a row memory with a sequencing engine.
// ----------------------------------------------------------------------------
// The block takes one input word at a time and stalls its input until every
// result word of that item is in the output register. The row memory has a
// single registered read port, so each row visit has a read and an evaluate
// state. A query scans the live rows, a claim checks every staged key against
// every live row, a release by lease moves the last row into each matching
// hole, and a release by owner first lists its distinct leases, then releases
// each. Non-final claim words are staged without a stall. Results leave
// through a one-word output register that holds while stalled.
// ----------------------------------------------------------------------------
module resource_lease_lock_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  rlt_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output rlt_pkg::t_out o_out_data
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_C_INV = 22'h000002,
        S_C_RD  = 22'h000004,
        S_C_EV  = 22'h000008,
        S_C_FUL = 22'h000010,
        S_C_WR  = 22'h000020,
        S_L_RD  = 22'h000040,
        S_L_EV  = 22'h000080,
        S_L_NOT = 22'h000100,
        S_L_MV  = 22'h000200,
        S_L_WB  = 22'h000400,
        S_L_END = 22'h000800,
        S_O_RD  = 22'h001000,
        S_O_EV  = 22'h002000,
        S_D_RD  = 22'h004000,
        S_D_EV  = 22'h008000,
        S_O_ADD = 22'h010000,
        S_P_RD  = 22'h020000,
        S_P_EV  = 22'h040000,
        S_Q_RD  = 22'h080000,
        S_Q_EV  = 22'h100000,
        S_PUSH  = 22'h200000
    } t_state;

    function automatic rlt_pkg::t_out mk_res(input logic kind, input rlt_pkg::t_status st,
                                             input logic [rlt_pkg::OWN_W-1:0] own,
                                             input logic [rlt_pkg::KEY_W-1:0] res,
                                             input rlt_pkg::t_lease lease, input logic last);
        rlt_pkg::t_out w;
        w.kind         = kind;
        w.status       = st;
        w.owner_out    = own;
        w.resource_out = res;
        w.lease_out    = lease;
        w.last_out     = last;
        return w;
    endfunction

    // state
    t_state                     r_state, n_state;
    rlt_pkg::t_action           r_cmd, n_cmd;
    rlt_pkg::t_cnt              r_i, n_i, r_pos, n_pos, r_cnt, n_cnt;
    rlt_pkg::t_cnt              r_idn, n_idn, r_k, n_k, r_p, n_p;
    rlt_pkg::t_scnt             r_j, n_j, r_scnt, n_scnt;
    rlt_pkg::t_lease            r_nl, n_nl, r_tgt, n_tgt;
    logic [rlt_pkg::KEY_W-1:0]  r_stg [rlt_pkg::MAX_GROUP];
    logic [rlt_pkg::KEY_W-1:0]  n_stg [rlt_pkg::MAX_GROUP];
    logic [rlt_pkg::OWN_W-1:0]  r_hown, n_hown, r_qown, n_qown;
    logic [rlt_pkg::KEY_W-1:0]  r_qkey, n_qkey;
    logic                       r_hmode, n_hmode, r_hnot, n_hnot;
    logic                       r_einv, n_einv, r_eovf, n_eovf;
    logic                       r_found, n_found, r_from_own, n_from_own;
    rlt_pkg::t_row              r_cur, n_cur;
    rlt_pkg::t_out              r_res, n_res;

    // memories
    rlt_pkg::t_row              row_mem [rlt_pkg::DEPTH];
    rlt_pkg::t_lease            ids_mem [rlt_pkg::DEPTH];
    rlt_pkg::t_row              r_rdata, w_wdata;
    rlt_pkg::t_lease            r_idata, w_iwdata;
    logic [rlt_pkg::ROW_AW-1:0] w_raddr, w_waddr, w_iraddr, w_iwaddr;
    logic                       w_we, w_iwe;

    // output
    logic                       w_push, w_can_push;
    rlt_pkg::t_out              w_push_data;

    rlt_pkg::t_cnt              w_pm1, w_cm1;
    logic                       w_acc;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_pm1      = r_pos - rlt_pkg::t_cnt'(1);
    assign w_cm1      = r_cnt - rlt_pkg::t_cnt'(1);

    always_comb begin
        unique case (r_state)
            S_L_RD:  w_raddr = w_pm1[rlt_pkg::ROW_AW-1:0];
            S_L_MV:  w_raddr = w_cm1[rlt_pkg::ROW_AW-1:0];
            default: w_raddr = r_i[rlt_pkg::ROW_AW-1:0];
        endcase
    end

    always_comb begin
        logic                       first, einv, eovf;
        rlt_pkg::t_lease            lease_inc;
        rlt_pkg::t_sum              need;
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_i        = r_i;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_idn      = r_idn;
        n_k        = r_k;
        n_p        = r_p;
        n_j        = r_j;
        n_scnt     = r_scnt;
        n_nl       = r_nl;
        n_tgt      = r_tgt;
        n_stg      = r_stg;
        n_hown     = r_hown;
        n_qown     = r_qown;
        n_qkey     = r_qkey;
        n_hmode    = r_hmode;
        n_hnot     = r_hnot;
        n_einv     = r_einv;
        n_eovf     = r_eovf;
        n_found    = r_found;
        n_from_own = r_from_own;
        n_cur      = r_cur;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = r_cnt[rlt_pkg::ROW_AW-1:0];
        w_wdata    = r_rdata;
        w_iwe      = 1'b0;
        w_iwaddr   = r_idn[rlt_pkg::ROW_AW-1:0];
        w_iwdata   = r_cur.lease;
        w_iraddr   = r_k[rlt_pkg::ROW_AW-1:0];
        w_push     = 1'b0;
        w_push_data = r_res;
        first      = (r_scnt == '0);
        einv       = 1'b0;
        eovf       = 1'b0;
        lease_inc  = r_nl + rlt_pkg::t_lease'(1);
        need       = rlt_pkg::t_sum'(r_cnt) + rlt_pkg::t_sum'(r_scnt);

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_cmd = i_in_data.action;
                    unique case (i_in_data.action)
                        rlt_pkg::ACT_CLAIM: begin
                            // header comes from the first word of the group
                            if (first) begin
                                n_hown  = i_in_data.owner_id;
                                n_hmode = i_in_data.mode;
                                n_hnot  = i_in_data.notify_on_release;
                                einv    = (i_in_data.owner_id == '0);
                                eovf    = 1'b0;
                            end else begin
                                einv = r_einv;
                                eovf = r_eovf;
                            end
                            if (i_in_data.resource_key == '0) begin
                                einv = 1'b1;
                            end
                            if (r_scnt < rlt_pkg::t_scnt'(rlt_pkg::MAX_GROUP)) begin
                                n_stg[r_scnt[rlt_pkg::STG_AW-1:0]] = i_in_data.resource_key;
                                n_scnt = r_scnt + rlt_pkg::t_scnt'(1);
                            end else begin
                                eovf = 1'b1;
                            end
                            n_einv = einv;
                            n_eovf = eovf;
                            if (i_in_data.group_last) begin
                                n_state = S_C_INV;
                            end
                        end
                        rlt_pkg::ACT_LEASE: begin
                            if (i_in_data.lease_in == '0) begin
                                n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_INVALID,
                                                 '0, '0, '0, 1'b1);
                                n_state = S_PUSH;
                            end else begin
                                n_tgt      = i_in_data.lease_in;
                                n_pos      = r_cnt;
                                n_found    = 1'b0;
                                n_from_own = 1'b0;
                                n_state    = S_L_RD;
                            end
                        end
                        rlt_pkg::ACT_OWNER: begin
                            if (i_in_data.owner_id == '0) begin
                                n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_INVALID,
                                                 '0, '0, '0, 1'b1);
                                n_state = S_PUSH;
                            end else begin
                                n_qown  = i_in_data.owner_id;
                                n_i     = '0;
                                n_idn   = '0;
                                n_state = S_O_RD;
                            end
                        end
                        rlt_pkg::ACT_QUERY: begin
                            if (i_in_data.resource_key == '0) begin
                                n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_INVALID,
                                                 '0, '0, '0, 1'b1);
                                n_state = S_PUSH;
                            end else begin
                                n_qkey  = i_in_data.resource_key;
                                n_i     = '0;
                                n_state = S_Q_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_C_INV: begin
                if (r_einv) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_INVALID,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                if (r_i == r_cnt) begin
                    // all rows checked for this staged key: next key
                    n_i = '0;
                    n_j = r_j + rlt_pkg::t_scnt'(1);
                    if (n_j == r_scnt) begin
                        n_state = S_C_FUL;
                    end
                end else begin
                    n_state = S_C_EV;
                end
            end
            S_C_EV: begin
                if (r_rdata.resource == r_stg[r_j[rlt_pkg::STG_AW-1:0]] &&
                    (!r_hmode || !r_rdata.mode)) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_CONFLICT,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_i     = r_i + rlt_pkg::t_cnt'(1);
                    n_state = S_C_RD;
                end
            end
            S_C_FUL: begin
                if (r_eovf || need > rlt_pkg::t_sum'(rlt_pkg::DEPTH)) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_FULL,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_tgt   = r_nl;
                    n_nl    = (lease_inc == '0) ? rlt_pkg::t_lease'(1) : lease_inc;
                    n_j     = '0;
                    n_state = S_C_WR;
                end
            end
            S_C_WR: begin
                if (r_j == r_scnt) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_OK,
                                     '0, '0, r_tgt, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    w_we             = 1'b1;
                    w_wdata.resource = r_stg[r_j[rlt_pkg::STG_AW-1:0]];
                    w_wdata.owner    = r_hown;
                    w_wdata.lease    = r_tgt;
                    w_wdata.mode     = r_hmode;
                    w_wdata.primary  = (r_j == '0);
                    w_wdata.notify   = (r_j == '0) && r_hnot;
                    n_cnt            = r_cnt + rlt_pkg::t_cnt'(1);
                    n_j              = r_j + rlt_pkg::t_scnt'(1);
                end
            end
            S_L_RD: begin
                n_state = (r_pos == '0) ? S_L_END : S_L_EV;
            end
            S_L_EV: begin
                n_cur = r_rdata;
                if (r_rdata.lease == r_tgt) begin
                    n_found = 1'b1;
                    n_state = (r_rdata.primary && r_rdata.notify) ? S_L_NOT : S_L_MV;
                end else begin
                    n_pos   = w_pm1;
                    n_state = S_L_RD;
                end
            end
            S_L_NOT: begin
                w_push      = 1'b1;
                w_push_data = mk_res(rlt_pkg::KIND_NOTICE, rlt_pkg::ST_OK, r_cur.owner,
                                     r_cur.resource, r_cur.lease, 1'b0);
                if (w_can_push) begin
                    n_state = S_L_MV;
                end
            end
            S_L_MV: begin
                n_state = S_L_WB;
            end
            S_L_WB: begin
                // swap the last row into the hole, then shrink
                w_waddr = w_pm1[rlt_pkg::ROW_AW-1:0];
                w_we    = (w_pm1 != w_cm1);
                n_cnt   = w_cm1;
                n_pos   = w_pm1;
                n_state = S_L_RD;
            end
            S_L_END: begin
                if (r_from_own) begin
                    n_p     = r_p + rlt_pkg::t_cnt'(1);
                    n_state = S_P_RD;
                end else begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS,
                                     r_found ? rlt_pkg::ST_OK : rlt_pkg::ST_NOTFOUND,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end
            end
            S_O_RD: begin
                if (r_i == r_cnt) begin
                    n_p     = '0;
                    n_state = S_P_RD;
                end else begin
                    n_state = S_O_EV;
                end
            end
            S_O_EV: begin
                if (r_rdata.owner == r_qown) begin
                    n_cur   = r_rdata;
                    n_k     = '0;
                    n_state = S_D_RD;
                end else begin
                    n_i     = r_i + rlt_pkg::t_cnt'(1);
                    n_state = S_O_RD;
                end
            end
            S_D_RD: begin
                n_state = (r_k == r_idn) ? S_O_ADD : S_D_EV;
            end
            S_D_EV: begin
                if (r_idata == r_cur.lease) begin
                    n_i     = r_i + rlt_pkg::t_cnt'(1);
                    n_state = S_O_RD;
                end else begin
                    n_k     = r_k + rlt_pkg::t_cnt'(1);
                    n_state = S_D_RD;
                end
            end
            S_O_ADD: begin
                w_iwe   = 1'b1;
                n_idn   = r_idn + rlt_pkg::t_cnt'(1);
                n_i     = r_i + rlt_pkg::t_cnt'(1);
                n_state = S_O_RD;
            end
            S_P_RD: begin
                w_iraddr = r_p[rlt_pkg::ROW_AW-1:0];
                if (r_p == r_idn) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_OK,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_state = S_P_EV;
                end
            end
            S_P_EV: begin
                n_tgt      = r_idata;
                n_pos      = r_cnt;
                n_from_own = 1'b1;
                n_state    = S_L_RD;
            end
            S_Q_RD: begin
                if (r_i == r_cnt) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_NOTFOUND,
                                     '0, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_state = S_Q_EV;
                end
            end
            S_Q_EV: begin
                if (r_rdata.resource == r_qkey) begin
                    n_res   = mk_res(rlt_pkg::KIND_STATUS, rlt_pkg::ST_OK,
                                     r_rdata.owner, '0, '0, 1'b1);
                    n_state = S_PUSH;
                end else begin
                    n_i     = r_i + rlt_pkg::t_cnt'(1);
                    n_state = S_Q_RD;
                end
            end
            S_PUSH: begin
                w_push = 1'b1;
                if (w_can_push) begin
                    if (r_cmd == rlt_pkg::ACT_CLAIM) begin
                        // claim finished: drop the staged group
                        n_scnt  = '0;
                        n_hown  = '0;
                        n_hmode = 1'b0;
                        n_hnot  = 1'b0;
                        n_einv  = 1'b0;
                        n_eovf  = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_nl    <= rlt_pkg::t_lease'(1);
            r_scnt  <= '0;
            r_hown  <= '0;
            r_hmode <= 1'b0;
            r_hnot  <= 1'b0;
            r_einv  <= 1'b0;
            r_eovf  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nl    <= n_nl;
            r_scnt  <= n_scnt;
            r_hown  <= n_hown;
            r_hmode <= n_hmode;
            r_hnot  <= n_hnot;
            r_einv  <= n_einv;
            r_eovf  <= n_eovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_i        <= n_i;
        r_pos      <= n_pos;
        r_idn      <= n_idn;
        r_k        <= n_k;
        r_p        <= n_p;
        r_j        <= n_j;
        r_tgt      <= n_tgt;
        r_stg      <= n_stg;
        r_qown     <= n_qown;
        r_qkey     <= n_qkey;
        r_found    <= n_found;
        r_from_own <= n_from_own;
        r_cur      <= n_cur;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            row_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= row_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_iwe) begin
            ids_mem[w_iwaddr] <= w_iwdata;
        end
        r_idata <= ids_mem[w_iraddr];
    end

    rlt_out_slot u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_push_data),
        .i_out_stall (i_out_stall),
        .o_can_push  (w_can_push),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/core/rlt_out_slot.sv
// ----------------------------------------------------------------------------
// Lease lock table output slot
// One-word output register that decouples the engine from the result sink.
// ----------------------------------------------------------------------------
module rlt_out_slot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rlt_pkg::t_out i_data,
    input  logic          i_out_stall,
    output logic          o_can_push,
    output logic          o_out_valid,
    output rlt_pkg::t_out o_out_data
);

    logic          r_ov;
    rlt_pkg::t_out r_word;

    assign o_can_push  = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_push && o_can_push) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_word <= i_data;
        end
    end

endmodule

// File: rtl/core/rlt_checker.sv
// ----------------------------------------------------------------------------
// Lease lock table port checker
// Watches the result channel of the lease table.
// ----------------------------------------------------------------------------
`include "resource_lease_lock_table_defines.svh"

module rlt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rlt_pkg::t_out o_out_data
);

    logic w_held, w_notice, w_status, w_notice_ok;

    assign w_held      = o_out_valid && i_out_stall;
    assign w_notice    = o_out_valid && (o_out_data.kind == rlt_pkg::KIND_NOTICE);
    assign w_status    = o_out_valid && (o_out_data.kind == rlt_pkg::KIND_STATUS);
    assign w_notice_ok = (o_out_data.status == rlt_pkg::ST_OK) && !o_out_data.last_out;

    `RLT_ASSERT_NEXT(a_out_hold, w_held, o_out_valid)
    `RLT_ASSERT_NEXT(a_out_stable, w_held, $stable(o_out_data))
    `RLT_ASSERT_NOW(a_notice_form, w_notice, w_notice_ok)
    `RLT_ASSERT_NOW(a_status_code, w_status, o_out_data.last_out)

endmodule

bind resource_lease_lock_table rlt_checker u_rlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
